/* rtl/prank_pkg.sv */
// ----------------------------------------------------------------------------
// prank_pkg
// Shared widths, register indexes and constants of the PageRank edge engine.
// ----------------------------------------------------------------------------
package prank_pkg;

    localparam int ID_W    = 10;   // node id fields
    localparam int NT_W    = 11;   // node count (largest id plus one)
    localparam int CNT_W   = 13;   // degree and edge count outputs
    localparam int RANK_W  = 32;   // Q16.16 rank
    localparam int DAMP_W  = 16;   // Q0.16 damping
    localparam int ITER_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIM  = 2'd2;

    localparam logic [DAMP_W-1:0] DAMPING_RST   = 16'd55706;
    localparam logic [RANK_W-1:0] THRESHOLD_RST = 32'd1;
    localparam logic [ITER_W-1:0] ITER_LIM_RST  = 16'd1000;

    localparam logic [RANK_W-1:0] RANK_ONE = 32'h0001_0000;
    localparam logic [CNT_W-1:0]  CNT_MAX  = 13'd8191;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic RES_SUMMARY = 1'b0;
    localparam logic RES_READ    = 1'b1;

endpackage

/* rtl/pagerank_edge_list_engine_core.sv */
// ----------------------------------------------------------------------------
// pagerank_edge_list_engine_core
// Streams a directed edge list and runs fixed-point PageRank power iteration.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the input channel (i_in_valid / o_in_stall). An
// edge request is written to the edge store when it is accepted. The request
// flagged as the last edge starts the run: node init, degree count per edge,
// then per iteration a division per node on the shared bit-serial divider,
// accumulation per edge, the damped update per node and bookkeeping. One
// summary result then appears on the output channel (o_out_valid /
// i_out_stall). A read request passes through ST_RDQ and then its answer is
// loaded into the output register. The block accepts no request while it
// computes or while a result waits in the output register; a stalled result
// simply holds. Configuration writes (i_cfg_we) take effect at once and are
// meant for idle periods. Reset restores the register defaults and forgets any
// graph; the edge and rank memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module pagerank_edge_list_engine_core #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [prank_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [prank_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic [prank_pkg::ID_W-1:0]          i_src_node,
    input  logic [prank_pkg::ID_W-1:0]          i_dst_node,
    input  logic                                i_last_edge,
    input  logic [prank_pkg::ID_W-1:0]          i_query_node,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_result_kind,
    output logic [prank_pkg::ID_W-1:0]          o_node_id,
    output logic [prank_pkg::CNT_W-1:0]         o_in_count,
    output logic [prank_pkg::CNT_W-1:0]         o_out_count,
    output logic [prank_pkg::RANK_W-1:0]        o_rank_value,
    output logic [prank_pkg::NT_W-1:0]          o_nodes_seen,
    output logic [prank_pkg::CNT_W-1:0]         o_edges_seen,
    output logic [prank_pkg::ITER_W-1:0]        o_iterations_done,
    output logic                                o_converged,
    output logic                                o_edges_dropped
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int SW = $clog2(MAX_EDGES + 1);   // edge count and degrees
    localparam int CW = prank_pkg::RANK_W + NW;  // summed change
    localparam int PW = prank_pkg::RANK_W + prank_pkg::DAMP_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RDQ, ST_INIT, ST_DEG_A, ST_DEG_B, ST_DEG_C, ST_ITER,
        ST_DIV_A, ST_DIV_B, ST_DIV_RUN, ST_DIV_W, ST_EDGE_A, ST_EDGE_B,
        ST_EDGE_C, ST_UPD_A, ST_UPD_B, ST_UPD_C, ST_UPD_D, ST_UPD_E,
        ST_CHECK, ST_DONE
    } t_state;

    function automatic logic [prank_pkg::CNT_W-1:0] sat_cnt(input logic [SW-1:0] x);
        logic [prank_pkg::CNT_W-1:0] res;
        res = (32'(x) > 32'(prank_pkg::CNT_MAX)) ? prank_pkg::CNT_MAX
                                                   : prank_pkg::CNT_W'(x);
        return res;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Configuration and control registers
    t_state                          r_state;
    logic [prank_pkg::DAMP_W-1:0]    r_damp;
    logic [prank_pkg::RANK_W-1:0]    r_thr;
    logic [prank_pkg::ITER_W-1:0]    r_limit;
    logic [SW-1:0]                   r_stored;
    logic [prank_pkg::NT_W-1:0]      r_nt;
    logic                            r_ovf;
    logic                            r_run_fin;
    logic [SW-1:0]                   r_ei;
    logic [prank_pkg::NT_W-1:0]      r_ni;
    logic [prank_pkg::ITER_W-1:0]    r_iters;
    logic                            r_conv;
    logic [CW-1:0]                   r_change;
    logic [4:0]                      r_cnt;
    logic                            r_out_valid;

    // Datapath registers
    logic [prank_pkg::ID_W-1:0]      r_q;
    logic [NW-1:0]                   r_s;
    logic [NW-1:0]                   r_d;
    logic [SW-1:0]                   r_rem;
    logic [SW-1:0]                   r_dvs;
    logic [31:0]                     r_quo;
    logic [PW-1:0]                   r_prod;
    logic [31:0]                     r_old;
    logic [31:0]                     r_v;
    logic [31:0]                     r_diff;

    // Output registers
    logic                            r_o_kind;
    logic [prank_pkg::ID_W-1:0]      r_o_node;
    logic [prank_pkg::CNT_W-1:0]     r_o_in;
    logic [prank_pkg::CNT_W-1:0]     r_o_out;
    logic [31:0]                     r_o_rank;
    logic [prank_pkg::NT_W-1:0]      r_o_nodes;
    logic [prank_pkg::CNT_W-1:0]     r_o_edges;
    logic [prank_pkg::ITER_W-1:0]    r_o_iters;
    logic                            r_o_conv;
    logic                            r_o_drop;

    // Memories and their registered read data
    logic [prank_pkg::ID_W-1:0] r_mem_esrc   [MAX_EDGES];
    logic [prank_pkg::ID_W-1:0] r_mem_edst   [MAX_EDGES];
    logic [SW-1:0]              r_mem_outdeg [MAX_NODES];
    logic [SW-1:0]              r_mem_indeg  [MAX_NODES];
    logic [31:0]                r_mem_rold   [MAX_NODES];
    logic [31:0]                r_mem_rnew   [MAX_NODES];
    logic [31:0]                r_mem_contr  [MAX_NODES];

    logic [prank_pkg::ID_W-1:0] r_esrc_q, r_edst_q;
    logic [SW-1:0]              r_outdeg_q, r_indeg_q;
    logic [31:0]                r_rold_q, r_rnew_q, r_contr_q;

    logic                     e_we;
    logic [EW-1:0]            e_wa, e_ra;
    logic                     od_we, id_we, ro_we, rn_we, ct_we;
    logic [NW-1:0]            od_wa, id_wa, ro_wa, rn_wa, ct_wa;
    logic [NW-1:0]            od_ra, id_ra, ro_ra, rn_ra, ct_ra;
    logic [SW-1:0]            od_wd, id_wd;
    logic [31:0]              ro_wd, rn_wd, ct_wd;

    // Edge-request bookkeeping
    logic                     in_acc;
    logic [SW-1:0]            base_st;
    logic [prank_pkg::NT_W-1:0] base_nt, s_p1, d_p1;
    logic                     drop;
    logic [SW-1:0]            n_stored;
    logic [prank_pkg::NT_W-1:0] n_nt;
    logic                     n_ovf;

    logic [SW:0]              trial;
    logic [16:0]              teleport;
    logic [prank_pkg::ITER_W-1:0] limit_eff;
    logic                     hit;
    logic [NW-1:0]            ni_a;

    assign o_in_stall = (r_state != ST_IDLE) || r_out_valid;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign ni_a       = NW'(r_ni);
    assign teleport   = 17'(prank_pkg::RANK_ONE) - 17'(r_damp);
    assign limit_eff  = (r_limit == '0) ? prank_pkg::ITER_W'(1) : r_limit;
    assign trial      = {r_rem, r_quo[31]};
    assign hit        = r_run_fin && (prank_pkg::NT_W'(r_q) < r_nt)
                        && (32'(r_q) < MAX_NODES);

    always_comb begin
        base_st  = r_run_fin ? '0 : r_stored;
        base_nt  = r_run_fin ? '0 : r_nt;
        s_p1     = prank_pkg::NT_W'(i_src_node) + 1'b1;
        d_p1     = prank_pkg::NT_W'(i_dst_node) + 1'b1;
        drop     = (32'(base_st) >= MAX_EDGES) || (32'(i_src_node) >= MAX_NODES)
                   || (32'(i_dst_node) >= MAX_NODES);
        n_ovf    = (r_run_fin ? 1'b0 : r_ovf) | drop;
        n_stored = drop ? base_st : base_st + 1'b1;
        n_nt     = base_nt;
        if (!drop) begin
            if (s_p1 > n_nt) begin
                n_nt = s_p1;
            end
            if (d_p1 > n_nt) begin
                n_nt = d_p1;
            end
        end
    end

    // Memory port steering per sequencer step
    always_comb begin
        e_we  = in_acc && (i_kind == prank_pkg::KIND_EDGE) && !drop;
        e_wa  = EW'(base_st);
        e_ra  = EW'(r_ei);
        od_we = 1'b0; od_wa = ni_a; od_wd = '0; od_ra = ni_a;
        id_we = 1'b0; id_wa = ni_a; id_wd = '0; id_ra = ni_a;
        ro_we = 1'b0; ro_wa = ni_a; ro_wd = r_v; ro_ra = ni_a;
        rn_we = 1'b0; rn_wa = ni_a; rn_wd = '0; rn_ra = ni_a;
        ct_we = 1'b0; ct_wa = ni_a; ct_wd = (r_dvs == '0) ? '0 : r_quo;
        ct_ra = NW'(r_esrc_q);
        case (r_state)
            ST_IDLE: begin
                od_ra = NW'(i_query_node);
                id_ra = NW'(i_query_node);
                ro_ra = NW'(i_query_node);
            end
            ST_INIT: begin
                od_we = 1'b1;
                id_we = 1'b1;
                ro_we = 1'b1;
                ro_wd = prank_pkg::RANK_ONE;
                rn_we = 1'b1;
            end
            ST_DEG_B: begin
                od_ra = NW'(r_esrc_q);
                id_ra = NW'(r_edst_q);
            end
            ST_DEG_C: begin
                od_we = 1'b1;
                od_wa = r_s;
                od_wd = r_outdeg_q + 1'b1;
                id_we = 1'b1;
                id_wa = r_d;
                id_wd = r_indeg_q + 1'b1;
            end
            ST_DIV_W: begin
                ct_we = 1'b1;
            end
            ST_EDGE_B: begin
                rn_ra = NW'(r_edst_q);
            end
            ST_EDGE_C: begin
                rn_we = 1'b1;
                rn_wa = r_d;
                rn_wd = sat_add(r_rnew_q, r_contr_q);
            end
            ST_UPD_D: begin
                ro_we = 1'b1;
                rn_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            r_mem_esrc[e_wa] <= i_src_node;
            r_mem_edst[e_wa] <= i_dst_node;
        end
        r_esrc_q <= r_mem_esrc[e_ra];
        r_edst_q <= r_mem_edst[e_ra];
    end

    always_ff @(posedge i_clk) begin
        if (od_we) begin
            r_mem_outdeg[od_wa] <= od_wd;
        end
        r_outdeg_q <= r_mem_outdeg[od_ra];
    end

    always_ff @(posedge i_clk) begin
        if (id_we) begin
            r_mem_indeg[id_wa] <= id_wd;
        end
        r_indeg_q <= r_mem_indeg[id_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ro_we) begin
            r_mem_rold[ro_wa] <= ro_wd;
        end
        r_rold_q <= r_mem_rold[ro_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rn_we) begin
            r_mem_rnew[rn_wa] <= rn_wd;
        end
        r_rnew_q <= r_mem_rnew[rn_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ct_we) begin
            r_mem_contr[ct_wa] <= ct_wd;
        end
        r_contr_q <= r_mem_contr[ct_ra];
    end

    // Sequencer, shared divider and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_damp      <= prank_pkg::DAMPING_RST;
            r_thr       <= prank_pkg::THRESHOLD_RST;
            r_limit     <= prank_pkg::ITER_LIM_RST;
            r_stored    <= '0;
            r_nt        <= '0;
            r_ovf       <= 1'b0;
            r_run_fin   <= 1'b0;
            r_ei        <= '0;
            r_ni        <= '0;
            r_iters     <= '0;
            r_conv      <= 1'b0;
            r_change    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    prank_pkg::CFG_DAMPING:   r_damp  <= i_cfg_data[prank_pkg::DAMP_W-1:0];
                    prank_pkg::CFG_THRESHOLD: r_thr   <= i_cfg_data;
                    prank_pkg::CFG_ITER_LIM:  r_limit <= i_cfg_data[prank_pkg::ITER_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_kind == prank_pkg::KIND_READ) begin
                            r_q     <= i_query_node;
                            r_state <= ST_RDQ;
                        end else begin
                            r_stored  <= n_stored;
                            r_nt      <= n_nt;
                            r_ovf     <= n_ovf;
                            r_run_fin <= 1'b0;
                            if (i_last_edge) begin
                                r_ni    <= '0;
                                r_iters <= '0;
                                r_conv  <= 1'b0;
                                r_state <= (n_nt == '0) ? ST_ITER : ST_INIT;
                            end
                        end
                    end
                end
                ST_RDQ: begin
                    r_out_valid <= 1'b1;
                    r_o_kind    <= prank_pkg::RES_READ;
                    r_o_node    <= r_q;
                    r_o_in      <= hit ? sat_cnt(r_indeg_q) : '0;
                    r_o_out     <= hit ? sat_cnt(r_outdeg_q) : '0;
                    r_o_rank    <= hit ? r_rold_q : '0;
                    r_o_nodes   <= '0;
                    r_o_edges   <= '0;
                    r_o_iters   <= '0;
                    r_o_conv    <= 1'b0;
                    r_o_drop    <= 1'b0;
                    r_state     <= ST_IDLE;
                end
                ST_INIT: begin
                    r_ni <= r_ni + 1'b1;
                    if (r_ni + 1'b1 >= r_nt) begin
                        r_ei    <= '0;
                        r_state <= (r_stored == '0) ? ST_ITER : ST_DEG_A;
                    end
                end
                ST_DEG_A: begin
                    r_state <= ST_DEG_B;
                end
                ST_DEG_B: begin
                    r_s     <= NW'(r_esrc_q);
                    r_d     <= NW'(r_edst_q);
                    r_state <= ST_DEG_C;
                end
                ST_DEG_C: begin
                    r_ei    <= r_ei + 1'b1;
                    r_state <= (r_ei + 1'b1 >= r_stored) ? ST_ITER : ST_DEG_A;
                end
                ST_ITER: begin
                    r_change <= '0;
                    r_ni     <= '0;
                    r_state  <= (r_nt == '0) ? ST_CHECK : ST_DIV_A;
                end
                ST_DIV_A: begin
                    r_state <= ST_DIV_B;
                end
                ST_DIV_B: begin
                    r_quo   <= r_rold_q;
                    r_dvs   <= r_outdeg_q;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV_RUN;
                end
                ST_DIV_RUN: begin
                    // Restoring division, one quotient bit per cycle.
                    if (trial >= {1'b0, r_dvs}) begin
                        r_rem <= SW'(trial - {1'b0, r_dvs});
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= trial[SW-1:0];
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) begin
                        r_state <= ST_DIV_W;
                    end
                end
                ST_DIV_W: begin
                    if (r_ni + 1'b1 < r_nt) begin
                        r_ni    <= r_ni + 1'b1;
                        r_state <= ST_DIV_A;
                    end else begin
                        r_ni    <= '0;
                        r_ei    <= '0;
                        r_state <= (r_stored == '0) ? ST_UPD_A : ST_EDGE_A;
                    end
                end
                ST_EDGE_A: begin
                    r_state <= ST_EDGE_B;
                end
                ST_EDGE_B: begin
                    r_d     <= NW'(r_edst_q);
                    r_state <= ST_EDGE_C;
                end
                ST_EDGE_C: begin
                    r_ei    <= r_ei + 1'b1;
                    r_state <= (r_ei + 1'b1 >= r_stored) ? ST_UPD_A : ST_EDGE_A;
                end
                ST_UPD_A: begin
                    r_state <= ST_UPD_B;
                end
                ST_UPD_B: begin
                    r_prod  <= PW'(r_damp) * PW'(r_rnew_q);
                    r_old   <= r_rold_q;
                    r_state <= ST_UPD_C;
                end
                ST_UPD_C: begin
                    r_v     <= sat_add(r_prod[PW-1:16], 32'(teleport));
                    r_state <= ST_UPD_D;
                end
                ST_UPD_D: begin
                    r_diff  <= (r_old > r_v) ? r_old - r_v : r_v - r_old;
                    r_state <= ST_UPD_E;
                end
                ST_UPD_E: begin
                    r_change <= r_change + CW'(r_diff);
                    r_ni     <= r_ni + 1'b1;
                    r_state  <= (r_ni + 1'b1 >= r_nt) ? ST_CHECK : ST_UPD_A;
                end
                ST_CHECK: begin
                    r_iters <= r_iters + 1'b1;
                    if (r_change <= CW'(r_thr)) begin
                        r_conv  <= 1'b1;
                        r_state <= ST_DONE;
                    end else if (r_iters + 1'b1 >= limit_eff) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_ITER;
                    end
                end
                ST_DONE: begin
                    r_run_fin   <= 1'b1;
                    r_out_valid <= 1'b1;
                    r_o_kind    <= prank_pkg::RES_SUMMARY;
                    r_o_node    <= '0;
                    r_o_in      <= '0;
                    r_o_out     <= '0;
                    r_o_rank    <= '0;
                    r_o_nodes   <= r_nt;
                    r_o_edges   <= sat_cnt(r_stored);
                    r_o_iters   <= r_iters;
                    r_o_conv    <= r_conv;
                    r_o_drop    <= r_ovf;
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_kind     = r_o_kind;
    assign o_node_id         = r_o_node;
    assign o_in_count        = r_o_in;
    assign o_out_count       = r_o_out;
    assign o_rank_value      = r_o_rank;
    assign o_nodes_seen      = r_o_nodes;
    assign o_edges_seen      = r_o_edges;
    assign o_iterations_done = r_o_iters;
    assign o_converged       = r_o_conv;
    assign o_edges_dropped   = r_o_drop;

endmodule

/* tb/sv/tb_pagerank_edge_list_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pagerank_edge_list_engine_core
// Streams edge lists and node reads into the PageRank engine, predicts every
// summary and read result with a fixed-point model of the power iteration,
// and compares each result field by field under random idling and stalls.
// ----------------------------------------------------------------------------
module tb_pagerank_edge_list_engine_core;
    import prank_pkg::*;

    localparam int NODE_CAP  = 1024;
    localparam int EDGE_CAP  = 4096;
    localparam int N_REQ     = 1500;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef enum logic [1:0] {ENT_REQ, ENT_CFG, ENT_DRAIN} entry_kind_e;

    typedef struct {
        entry_kind_e          ek;
        logic                 kind;
        logic [ID_W-1:0]      src;
        logic [ID_W-1:0]      dst;
        logic                 last;
        logic [ID_W-1:0]      query;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
    } entry_t;

    typedef struct {
        logic              rkind;
        logic [ID_W-1:0]   node;
        logic [CNT_W-1:0]  in_c;
        logic [CNT_W-1:0]  out_c;
        logic [RANK_W-1:0] rank;
        logic [NT_W-1:0]   nodes;
        logic [CNT_W-1:0]  edges;
        logic [ITER_W-1:0] iters;
        logic              conv;
        logic              dropped;
    } result_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_kind;
    logic [ID_W-1:0]      i_src_node;
    logic [ID_W-1:0]      i_dst_node;
    logic                 i_last_edge;
    logic [ID_W-1:0]      i_query_node;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_result_kind;
    logic [ID_W-1:0]      o_node_id;
    logic [CNT_W-1:0]     o_in_count;
    logic [CNT_W-1:0]     o_out_count;
    logic [RANK_W-1:0]    o_rank_value;
    logic [NT_W-1:0]      o_nodes_seen;
    logic [CNT_W-1:0]     o_edges_seen;
    logic [ITER_W-1:0]    o_iterations_done;
    logic                 o_converged;
    logic                 o_edges_dropped;

    pagerank_edge_list_engine_core u_top (.*);

    // Stimulus queue, expected results and the engine model.
    entry_t  stim_q[$];
    result_t expect_q[$];
    entry_t  on_bus;
    int      n_req_total, n_req_sent, settle, errors;
    int      n_reads, n_summaries, n_unconverged, n_dropped_runs;
    longint  cycles;

    logic [DAMP_W-1:0] pr_damping;
    logic [RANK_W-1:0] pr_threshold;
    logic [ITER_W-1:0] pr_limit;
    logic [ID_W-1:0]   pr_src[EDGE_CAP];
    logic [ID_W-1:0]   pr_dst[EDGE_CAP];
    int                pr_edges, pr_nodes;
    int                pr_in[NODE_CAP];
    int                pr_out[NODE_CAP];
    logic [RANK_W-1:0] pr_rank[NODE_CAP];
    logic [RANK_W-1:0] pr_acc[NODE_CAP];
    bit                pr_finished, pr_overflow;

    function automatic logic [RANK_W-1:0] sat_add(logic [RANK_W-1:0] a,
                                                  logic [RANK_W-1:0] b);
        logic [RANK_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[RANK_W] ? '1 : s[RANK_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_cnt(int d);
        return d > 8191 ? CNT_MAX : CNT_W'(d);
    endfunction

    task automatic clear_graph();
        pr_edges = 0;
        pr_nodes = 0;
        pr_overflow = 0;
        pr_finished = 0;
        for (int i = 0; i < NODE_CAP; i++) begin
            pr_in[i] = 0;
            pr_out[i] = 0;
        end
    endtask

    task automatic run_iterations(output int iters, output bit conv);
        longint unsigned  change;
        int               lim;
        int               u;
        logic [RANK_W-1:0] tele, v, scaled;
        logic [63:0]      prod;
        tele = RANK_W'(32'd65536 - pr_damping);
        lim = (pr_limit == 0) ? 1 : int'(pr_limit);
        for (int i = 0; i < pr_nodes; i++) begin
            pr_rank[i] = RANK_ONE;
            pr_acc[i] = '0;
        end
        for (int e = 0; e < pr_edges; e++) begin
            pr_out[pr_src[e]]++;
            pr_in[pr_dst[e]]++;
        end
        iters = 0;
        conv = 0;
        forever begin
            change = 0;
            for (int e = 0; e < pr_edges; e++) begin
                u = pr_src[e];
                if (pr_out[u] != 0)
                    pr_acc[pr_dst[e]] = sat_add(pr_acc[pr_dst[e]],
                                                pr_rank[u] / pr_out[u]);
            end
            for (int i = 0; i < pr_nodes; i++) begin
                prod = 64'(pr_damping) * 64'(pr_acc[i]);
                scaled = prod[47:16];
                v = sat_add(scaled, tele);
                change += (pr_rank[i] > v) ? pr_rank[i] - v : v - pr_rank[i];
                pr_rank[i] = v;
                pr_acc[i] = '0;
            end
            iters++;
            if (change <= pr_threshold) begin
                conv = 1;
                return;
            end
            if (iters >= lim)
                return;
        end
    endtask

    // Works out the result, if any, that one accepted request causes.
    task automatic predict_request(entry_t r);
        result_t x;
        int      iters;
        bit      conv;
        x = '{default: '0};
        if (r.kind == KIND_READ) begin
            x.rkind = RES_READ;
            x.node = r.query;
            if (pr_finished && r.query < pr_nodes) begin
                x.in_c = sat_cnt(pr_in[r.query]);
                x.out_c = sat_cnt(pr_out[r.query]);
                x.rank = pr_rank[r.query];
            end
            expect_q.push_back(x);
            n_reads++;
        end else begin
            if (pr_finished)
                clear_graph();
            if (pr_edges >= EDGE_CAP) begin
                pr_overflow = 1;
            end else begin
                pr_src[pr_edges] = r.src;
                pr_dst[pr_edges] = r.dst;
                pr_edges++;
                if (r.src + 1 > pr_nodes)
                    pr_nodes = r.src + 1;
                if (r.dst + 1 > pr_nodes)
                    pr_nodes = r.dst + 1;
            end
            if (r.last) begin
                run_iterations(iters, conv);
                pr_finished = 1;
                x.rkind = RES_SUMMARY;
                x.nodes = NT_W'(pr_nodes);
                x.edges = sat_cnt(pr_edges);
                x.iters = ITER_W'(iters);
                x.conv = conv;
                x.dropped = pr_overflow;
                expect_q.push_back(x);
                n_summaries++;
                if (!conv)
                    n_unconverged++;
                if (pr_overflow)
                    n_dropped_runs++;
            end
        end
    endtask

    // Stimulus builders.
    task automatic add_req(logic kind, int src, int dst, logic last, int query);
        entry_t r;
        r = '{ek: ENT_REQ, default: '0};
        r.kind = kind;
        r.src = ID_W'(src);
        r.dst = ID_W'(dst);
        r.last = last;
        r.query = ID_W'(query);
        stim_q.push_back(r);
        n_req_total++;
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        entry_t r;
        r = '{ek: ENT_CFG, default: '0};
        r.idx = idx;
        r.data = data;
        stim_q.push_back(r);
    endtask

    task automatic add_drain();
        entry_t r;
        r = '{ek: ENT_DRAIN, default: '0};
        stim_q.push_back(r);
    endtask

    task automatic add_setup(int damp, longint thr, int lim);
        add_cfg(CFG_DAMPING, CFG_DAT_W'(damp));
        add_cfg(CFG_THRESHOLD, CFG_DAT_W'(thr));
        add_cfg(CFG_ITER_LIM, CFG_DAT_W'(lim));
    endtask

    // A random graph with ids up to max_id; noisy graphs mix reads into the load.
    task automatic add_graph(int n_edges, int max_id, bit noisy);
        for (int e = 0; e < n_edges; e++) begin
            if (noisy && $urandom_range(0, 4) == 0)
                add_req(KIND_READ, $urandom, $urandom, $urandom, $urandom_range(0, max_id + 2));
            add_req(KIND_EDGE, $urandom_range(0, max_id), $urandom_range(0, max_id),
                    e == n_edges - 1, $urandom);
        end
        repeat ($urandom_range(1, 5))
            add_req(KIND_READ, $urandom, $urandom, $urandom, $urandom_range(0, max_id + 2));
    endtask

    task automatic build_stimulus();
        int max_id;
        // Reads with no finished run.
        add_req(KIND_READ, 0, 0, 1, 0);
        add_req(KIND_READ, 1023, 1023, 0, 1023);
        // Self loop at reset settings: converges after one iteration.
        add_req(KIND_EDGE, 0, 0, 1, 0);
        add_req(KIND_READ, 0, 0, 0, 0);
        add_req(KIND_READ, 0, 0, 0, 1);
        // Largest node id, converged within a short limit.
        add_setup(55706, 0, 3);
        add_req(KIND_EDGE, 1023, 0, 0, 0);
        add_req(KIND_EDGE, 0, 1023, 1, 0);
        add_req(KIND_READ, 0, 0, 0, 1023);
        add_req(KIND_READ, 0, 0, 0, 512);
        // Zero damping converges at once even with a zero threshold.
        add_setup(0, 0, 65535);
        add_req(KIND_EDGE, 10'h155, 10'h2AA, 0, 0);
        add_req(KIND_EDGE, 10'h2AA, 10'h155, 1, 0);
        add_req(KIND_READ, 0, 0, 0, 10'h2AA);
        // Full damping, any change accepted.
        add_setup(65535, 64'hFFFF_FFFF, 1);
        add_req(KIND_EDGE, 1, 2, 0, 0);
        add_req(KIND_EDGE, 1, 3, 0, 0);
        add_req(KIND_EDGE, 3, 1, 1, 0);
        add_req(KIND_READ, 0, 0, 0, 1);
        add_req(KIND_READ, 0, 0, 0, 2);
        // Store full: the last edge is dropped and the run still starts.
        add_setup(55706, 1000, 1);
        for (int e = 0; e <= EDGE_CAP; e++)
            add_req(KIND_EDGE, $urandom_range(0, 7), $urandom_range(0, 7), e == EDGE_CAP, 0);
        add_req(KIND_READ, 0, 0, 0, 3);
        add_drain();
        // Random graphs, most of them small so that the iteration stays short.
        while (n_req_total < N_REQ + EDGE_CAP) begin
            if ($urandom_range(0, 19) == 0) begin
                max_id = $urandom_range(0, 1023);
                add_setup($urandom, $urandom, $urandom_range(1, 2));
            end else begin
                max_id = $urandom_range(0, 7);
                case ($urandom_range(0, 3))
                    0: add_setup($urandom, $urandom, $urandom_range(1, 8));
                    1: add_setup($urandom_range(40000, 65535), $urandom_range(0, 4096),
                                 $urandom_range(1, 12));
                    default: add_setup($urandom_range(50000, 60000), $urandom_range(0, 300),
                                       $urandom_range(1, 8));
                endcase
            end
            add_graph($urandom_range(1, 20), max_id, $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0)
                add_drain();
        end
    endtask

    function automatic int idle_pct(bit sender);
        if (n_req_sent < n_req_total / 3)
            return sender ? 29 : 46;
        else if (n_req_sent < 2 * n_req_total / 3)
            return sender ? 46 : 29;
        return 0;
    endfunction

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Request driver: configuration writes and pauses wait for an idle engine.
    always @(posedge i_clk) begin
        logic   nxt_valid, nxt_we;
        entry_t head;
        if (!i_rst_n) begin
            i_in_valid <= 0;
            i_cfg_we <= 0;
            i_cfg_index <= '0;
            i_cfg_data <= '0;
            settle = 0;
        end else begin
            nxt_valid = i_in_valid;
            nxt_we = 0;
            if (i_in_valid && !o_in_stall) begin
                predict_request(on_bus);
                n_req_sent++;
                nxt_valid = 0;
            end
            settle = (expect_q.size() == 0) ? settle + 1 : 0;
            if (!nxt_valid && stim_q.size() != 0) begin
                head = stim_q[0];
                case (head.ek)
                    ENT_CFG: begin
                        if (settle >= 8) begin
                            nxt_we = 1;
                            i_cfg_index <= head.idx;
                            i_cfg_data <= head.data;
                            case (head.idx)
                                CFG_DAMPING:   pr_damping = head.data[DAMP_W-1:0];
                                CFG_THRESHOLD: pr_threshold = head.data;
                                CFG_ITER_LIM:  pr_limit = head.data[ITER_W-1:0];
                                default: ;
                            endcase
                            void'(stim_q.pop_front());
                        end
                    end
                    ENT_DRAIN: begin
                        if (settle >= 8)
                            void'(stim_q.pop_front());
                    end
                    default: begin
                        if ($urandom_range(0, 99) >= idle_pct(1)) begin
                            on_bus = stim_q.pop_front();
                            nxt_valid = 1;
                            i_kind <= on_bus.kind;
                            i_src_node <= on_bus.src;
                            i_dst_node <= on_bus.dst;
                            i_last_edge <= on_bus.last;
                            i_query_node <= on_bus.query;
                        end
                    end
                endcase
            end
            i_in_valid <= nxt_valid;
            i_cfg_we <= nxt_we;
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        result_t x;
        if (!i_rst_n) begin
            i_out_stall <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expect_q.size() == 0) begin
                    $display("%0t: result with nothing expected, kind %0b", $time,
                             o_result_kind);
                    errors++;
                end else begin
                    x = expect_q.pop_front();
                    if (o_result_kind !== x.rkind || o_node_id !== x.node ||
                        o_in_count !== x.in_c || o_out_count !== x.out_c ||
                        o_rank_value !== x.rank || o_nodes_seen !== x.nodes ||
                        o_edges_seen !== x.edges || o_iterations_done !== x.iters ||
                        o_converged !== x.conv || o_edges_dropped !== x.dropped) begin
                        $display({"%0t: mismatch expected kind %0b node %0d in %0d ",
                                  "out %0d rank %h nodes %0d edges %0d iters %0d ",
                                  "conv %0b drop %0b"},
                                 $time, x.rkind, x.node, x.in_c, x.out_c, x.rank, x.nodes,
                                 x.edges, x.iters, x.conv, x.dropped);
                        $display({"%0t:          actual   kind %0b node %0d in %0d ",
                                  "out %0d rank %h nodes %0d edges %0d iters %0d ",
                                  "conv %0b drop %0b"},
                                 $time, o_result_kind, o_node_id, o_in_count, o_out_count,
                                 o_rank_value, o_nodes_seen, o_edges_seen,
                                 o_iterations_done, o_converged, o_edges_dropped);
                        errors++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < idle_pct(0));
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expect_q.size());
            $display("tb_pagerank_edge_list_engine_core: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 0;
        i_kind = 0;
        i_src_node = '0;
        i_dst_node = '0;
        i_last_edge = 0;
        i_query_node = '0;
        i_out_stall = 0;
        pr_damping = DAMPING_RST;
        pr_threshold = THRESHOLD_RST;
        pr_limit = ITER_LIM_RST;
        clear_graph();
        build_stimulus();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        while (stim_q.size() != 0 || i_in_valid || expect_q.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d requests: %0d runs (%0d unconverged, %0d with dropped edges)",
                 n_req_sent, n_summaries, n_unconverged, n_dropped_runs);
        $display("and %0d node reads; %0d mismatches.", n_reads, errors);
        if (errors == 0 && expect_q.size() == 0)
            $display("tb_pagerank_edge_list_engine_core: PASS");
        else
            $display("tb_pagerank_edge_list_engine_core: FAIL");
        $finish;
    end

endmodule
